// ===== src/coap_header_option_parser_macros.svh =====
// Assertion macros for the CoAP header and option parser.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef COAP_HEADER_OPTION_PARSER_MACROS_SVH
`define COAP_HEADER_OPTION_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CHOP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("chop assertion failed");

// next-cycle implication
`define CHOP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("chop assertion failed");

`else

`define CHOP_ASSERT_NOW(label, ante, cons)
`define CHOP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/chop_pkg.sv =====
// Shared types and constants for the CoAP header and option parser.
// No dependencies.
package chop_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_DESC,
      PH_DELTA_EXT,
      PH_LEN_EXT,
      PH_VALUE,
      PH_DONE
   } phase_type;

   localparam logic [3:0]  EXT_NIBBLE     = 4'd13;
   localparam logic [11:0] URI_PATH_OPT   = 12'd11;
   localparam logic [11:0] BLOCK2_OPT     = 12'd23;
   localparam logic [11:0] BLOCK1_OPT     = 12'd27;
   localparam logic [11:0] OPT_MAX        = 12'd4095;
   localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
   localparam logic [8:0]  MAX_URI_LENGTH = 9'd268;

   typedef struct packed {
      logic [3:0] token_length;
      logic [7:0] method_code;
      logic [7:0] uri_offset;
      logic [8:0] uri_length;
      logic [7:0] block_value;
      logic [8:0] payload_offset;
   } result_type;

endpackage

// ===== src/chop_if.sv =====
// Valid/ready channel interfaces for the CoAP header and option parser.
// Depends on nothing; payload fields are plain vectors.
interface chop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface chop_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_length;
   logic [7:0] method_code;
   logic [7:0] uri_offset;
   logic [8:0] uri_length;
   logic [7:0] block_value;
   logic [8:0] payload_offset;

   modport source (output valid, output token_length, output method_code,
                   output uri_offset, output uri_length, output block_value,
                   output payload_offset, input ready);
   modport sink   (input valid, input token_length, input method_code,
                   input uri_offset, input uri_length, input block_value,
                   input payload_offset, output ready);
endinterface

// ===== src/chop_scanner.sv =====
// Byte-serial scanner state: header, token skip and option walk.
// Depends on chop_pkg.
module chop_scanner import chop_pkg::*; #(
   parameter int PACKET_BYTES = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_value,
   input  logic       last_byte,
   output result_type result
);

   localparam int POS_W = $clog2(PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PACKET_BYTES);

   logic [POS_W-1:0] pos_ff, pos_in;
   phase_type        phase_ff, phase_in;
   logic [11:0]      opt_ff, opt_in;
   logic [3:0]       len_nib_ff, len_nib_in;
   logic [8:0]       skip_ff, skip_in;
   logic [3:0]       tkl_ff, tkl_in;
   logic [7:0]       method_ff, method_in;
   logic [7:0]       uri_off_ff, uri_off_in;
   logic [8:0]       uri_len_ff, uri_len_in;
   logic [7:0]       block_ff, block_in;
   logic             capture_ff, capture_in;
   logic [8:0]       payload_ff, payload_in;

   logic [POS_W-1:0] pos_plus;
   logic [POS_W+8:0] pos_ext;
   logic [8:0]       add_amt;
   logic [12:0]      opt_sum;
   logic [11:0]      opt_sat;
   logic [8:0]       ext_len;
   logic [3:0]       len_nib;
   logic             start_value;
   logic [8:0]       value_len;

   assign pos_plus = pos_ff + POS_W'(1);
   assign pos_ext  = {{9{1'b0}}, pos_plus};
   assign ext_len  = 9'(EXT_NIBBLE) + {1'b0, byte_value};
   assign add_amt  = (phase_ff == PH_DELTA_EXT) ? ext_len : {5'b0, byte_value[7:4]};
   assign opt_sum  = {1'b0, opt_ff} + {4'b0, add_amt};
   assign opt_sat  = opt_sum[12] ? OPT_MAX : opt_sum[11:0];
   // length nibble: fresh from the descriptor, or held across a delta extension
   assign len_nib  = (phase_ff == PH_DESC) ? byte_value[3:0] : len_nib_ff;

   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      opt_in      = opt_ff;
      len_nib_in  = len_nib_ff;
      skip_in     = skip_ff;
      tkl_in      = tkl_ff;
      method_in   = method_ff;
      uri_off_in  = uri_off_ff;
      uri_len_in  = uri_len_ff;
      block_in    = block_ff;
      capture_in  = capture_ff;
      payload_in  = payload_ff;
      start_value = 1'b0;
      value_len   = '0;

      if (pos_ff < POS_LIMIT) begin
         pos_in = pos_plus;
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == '0) begin
                  tkl_in = byte_value[3:0];
               end else if (pos_ff == POS_W'(1)) begin
                  method_in = byte_value;
               end else if (pos_ff == POS_W'(3)) begin
                  skip_in  = {5'b0, tkl_ff};
                  phase_in = (tkl_ff != '0) ? PH_TOKEN : PH_DESC;
               end
            end
            PH_TOKEN: begin
               skip_in = skip_ff - 9'd1;
               if (skip_ff == 9'd1) phase_in = PH_DESC;
            end
            PH_DESC: begin
               if (byte_value == PAYLOAD_MARKER) begin
                  payload_in = pos_ext[8:0];
                  phase_in   = PH_DONE;
               end else if (byte_value == '0) begin
                  phase_in = PH_DONE;
               end else begin
                  len_nib_in = byte_value[3:0];
                  if (byte_value[7:4] == EXT_NIBBLE) begin
                     phase_in = PH_DELTA_EXT;
                  end else begin
                     opt_in = opt_sat;
                     if (len_nib == EXT_NIBBLE) phase_in = PH_LEN_EXT;
                     else begin
                        start_value = 1'b1;
                        value_len   = {5'b0, len_nib};
                     end
                  end
               end
            end
            PH_DELTA_EXT: begin
               opt_in = opt_sat;
               if (len_nib == EXT_NIBBLE) phase_in = PH_LEN_EXT;
               else begin
                  start_value = 1'b1;
                  value_len   = {5'b0, len_nib};
               end
            end
            PH_LEN_EXT: begin
               start_value = 1'b1;
               value_len   = ext_len;
            end
            PH_VALUE: begin
               if (capture_ff) begin
                  block_in   = byte_value;
                  capture_in = 1'b0;
               end
               skip_in = skip_ff - 9'd1;
               if (skip_ff == 9'd1) phase_in = PH_DESC;
            end
            default: begin
            end
         endcase

         if (start_value) begin
            if (opt_in == URI_PATH_OPT) begin
               uri_off_in = pos_ext[7:0];
               uri_len_in = value_len;
            end
            if (opt_in == BLOCK2_OPT || opt_in == BLOCK1_OPT) begin
               block_in   = '0;
               capture_in = value_len[0];
            end
            skip_in  = value_len;
            phase_in = (value_len != '0) ? PH_VALUE : PH_DESC;
         end
      end

      result.token_length   = tkl_in;
      result.method_code    = method_in;
      result.uri_offset     = uri_off_in;
      result.uri_length     = uri_len_in;
      result.block_value    = block_in;
      result.payload_offset = payload_in;

      // last byte of the datagram: start over for the next one
      if (last_byte) begin
         pos_in     = '0;
         phase_in   = PH_HEADER;
         opt_in     = '0;
         len_nib_in = '0;
         skip_in    = '0;
         tkl_in     = '0;
         method_in  = '0;
         uri_off_in = '0;
         uri_len_in = '0;
         block_in   = '0;
         capture_in = 1'b0;
         payload_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= PH_HEADER;
         opt_ff     <= '0;
         len_nib_ff <= '0;
         skip_ff    <= '0;
         tkl_ff     <= '0;
         method_ff  <= '0;
         uri_off_ff <= '0;
         uri_len_ff <= '0;
         block_ff   <= '0;
         capture_ff <= 1'b0;
         payload_ff <= '0;
      end else if (step) begin
         pos_ff     <= pos_in;
         phase_ff   <= phase_in;
         opt_ff     <= opt_in;
         len_nib_ff <= len_nib_in;
         skip_ff    <= skip_in;
         tkl_ff     <= tkl_in;
         method_ff  <= method_in;
         uri_off_ff <= uri_off_in;
         uri_len_ff <= uri_len_in;
         block_ff   <= block_in;
         capture_ff <= capture_in;
         payload_ff <= payload_in;
      end
   end

endmodule

// ===== src/coap_header_option_parser.sv =====
// CoAP header and option parser. Takes one datagram byte per cycle while not stalled,
// and in the cycle after the byte flagged last_byte is taken presents a single result in
// the output register. The only stall: a last byte is held off while the
// previous result still sits in the output register untaken; other bytes are
// taken regardless. Bytes at offset PACKET_BYTES and beyond are ignored.
// Depends on chop_pkg, chop_if, chop_scanner and the macros header.
`include "coap_header_option_parser_macros.svh"

module coap_header_option_parser import chop_pkg::*; #(
   parameter int PACKET_BYTES = 256
) (
   input  logic      clock,
   input  logic      reset,
   chop_req_if.sink   req_ch,
   chop_rsp_if.source rsp_ch
);

   logic       step;
   logic       load;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type scan_result;
   result_type result_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready || !req_ch.last_byte;
   assign step         = req_ch.valid && req_ch.ready;
   assign load         = step && req_ch.last_byte;

   chop_scanner #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_scanner (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (req_ch.byte_value),
      .last_byte  (req_ch.last_byte),
      .result     (scan_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) result_ff <= scan_result;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.token_length   = result_ff.token_length;
   assign rsp_ch.method_code    = result_ff.method_code;
   assign rsp_ch.uri_offset     = result_ff.uri_offset;
   assign rsp_ch.uri_length     = result_ff.uri_length;
   assign rsp_ch.block_value    = result_ff.block_value;
   assign rsp_ch.payload_offset = result_ff.payload_offset;

   // a finished datagram always shows up on the result side next cycle
   `CHOP_ASSERT_NEXT(a_load_shows, load, rsp_valid_ff)
   // an untaken result is never overwritten by a new datagram end
   `CHOP_ASSERT_NOW(a_no_overwrite, rsp_valid_ff && !rsp_ch.ready, !load)
   // URI length is a nibble or an extension byte plus thirteen
   `CHOP_ASSERT_NOW(a_uri_len_range, rsp_valid_ff, result_ff.uri_length <= MAX_URI_LENGTH)

endmodule

// ===== verif/testbench.sv =====
// Testbench for coap_header_option_parser: feeds datagrams one byte per transaction and
// checks every report against a scanner model kept here. Depends on chop_pkg, chop_if
// and the coap_header_option_parser RTL.
module testbench import chop_pkg::*;;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 9;
   localparam int FRAME_LIMIT  = 256;
   localparam int BYTE_TARGET  = 1200;
   localparam int MIN_FRAMES   = 20;
   localparam int DRAIN_CYCLES = 10;
   localparam int RUN_LIMIT    = 2000000;
   localparam int MAX_EXT      = 268;
   localparam logic [7:0] OPTIONS_END = 8'h00;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic clock;
   logic reset;

   chop_req_if req_ch();
   chop_rsp_if rsp_ch();

   coap_header_option_parser #(.PACKET_BYTES(FRAME_LIMIT)) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   frame_byte_type byte_queue[$];
   result_type     expected_reports[$];
   logic [7:0]     frame_q[$];
   int             error_count = 0;
   int             queued_bytes = 0;
   int             queued_frames = 0;

   // scanner model state
   int         scan_pos;
   phase_type  scan_phase;
   logic [11:0] opt_number;
   logic [7:0] desc_byte;
   int         skip_count;
   logic [3:0] seen_tkl;
   logic [7:0] seen_code;
   logic [7:0] seen_uri_offset;
   logic [8:0] seen_uri_length;
   logic [7:0] seen_block;
   logic       block_armed;
   logic [8:0] seen_payload;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic clear_scanner();
      scan_pos = 0;
      scan_phase = PH_HEADER;
      opt_number = '0;
      desc_byte = '0;
      skip_count = 0;
      seen_tkl = '0;
      seen_code = '0;
      seen_uri_offset = '0;
      seen_uri_length = '0;
      seen_block = '0;
      block_armed = 1'b0;
      seen_payload = '0;
   endtask

   task automatic bump_option(input int amount);
      int sum;
      sum = int'(opt_number) + amount;
      opt_number = (sum > int'(OPT_MAX)) ? OPT_MAX : sum[11:0];
   endtask

   task automatic open_value(input int offset, input int len);
      if (opt_number == URI_PATH_OPT) begin
         seen_uri_offset = offset[7:0];
         seen_uri_length = len[8:0];
      end
      if (opt_number == BLOCK2_OPT || opt_number == BLOCK1_OPT) begin
         seen_block = '0;
         block_armed = len[0];
      end
      skip_count = len;
      scan_phase = (len != 0) ? PH_VALUE : PH_DESC;
   endtask

   task automatic close_delta(input int pos);
      if (desc_byte[3:0] == EXT_NIBBLE) scan_phase = PH_LEN_EXT;
      else open_value(pos + 1, int'(desc_byte[3:0]));
   endtask

   task automatic scan_byte(input int pos, input logic [7:0] b);
      int next_pos;
      next_pos = pos + 1;
      case (scan_phase)
         PH_HEADER: begin
            if (pos == 0) seen_tkl = b[3:0];
            else if (pos == 1) seen_code = b;
            else if (pos == 3) begin
               skip_count = int'(seen_tkl);
               scan_phase = (seen_tkl != 0) ? PH_TOKEN : PH_DESC;
            end
         end
         PH_TOKEN: begin
            skip_count--;
            if (skip_count == 0) scan_phase = PH_DESC;
         end
         PH_DESC: begin
            if (b == PAYLOAD_MARKER) begin
               seen_payload = next_pos[8:0];
               scan_phase = PH_DONE;
            end else if (b == OPTIONS_END) begin
               scan_phase = PH_DONE;
            end else begin
               desc_byte = b;
               if (b[7:4] == EXT_NIBBLE) scan_phase = PH_DELTA_EXT;
               else begin
                  bump_option(int'(b[7:4]));
                  close_delta(pos);
               end
            end
         end
         PH_DELTA_EXT: begin
            bump_option(int'(EXT_NIBBLE) + int'(b));
            close_delta(pos);
         end
         PH_LEN_EXT: open_value(next_pos, int'(EXT_NIBBLE) + int'(b));
         PH_VALUE: begin
            if (block_armed) begin
               seen_block = b;
               block_armed = 1'b0;
            end
            skip_count--;
            if (skip_count == 0) scan_phase = PH_DESC;
         end
         default: ;
      endcase
   endtask

   task automatic predict_byte(input frame_byte_type item);
      result_type r;
      if (scan_pos < FRAME_LIMIT) begin
         scan_byte(scan_pos, item.value);
         scan_pos++;
      end
      if (item.last) begin
         r.token_length = seen_tkl;
         r.method_code = seen_code;
         r.uri_offset = seen_uri_offset;
         r.uri_length = seen_uri_length;
         r.block_value = seen_block;
         r.payload_offset = seen_payload;
         expected_reports.push_back(r);
         clear_scanner();
      end
   endtask

   // ---- datagram construction ----

   task automatic put_bytes(input int count);
      repeat (count) frame_q.push_back(8'($urandom_range(0, 255)));
   endtask

   // nibble 13 always takes an extension byte; 14 and 15 may go either way
   task automatic encode_field(input int v, output logic [3:0] nib, output int ext);
      if (v < 13 || (v > 13 && v < 16 && $urandom_range(0, 1) == 1)) begin
         nib = v[3:0];
         ext = -1;
      end else begin
         nib = EXT_NIBBLE;
         ext = v - int'(EXT_NIBBLE);
      end
   endtask

   task automatic put_option(input int delta, input int len);
      logic [3:0] dn;
      logic [3:0] ln;
      int dx;
      int lx;
      encode_field(delta, dn, dx);
      encode_field(len, ln, lx);
      frame_q.push_back({dn, ln});
      if (dx >= 0) frame_q.push_back(dx[7:0]);
      if (lx >= 0) frame_q.push_back(lx[7:0]);
      put_bytes(len);
   endtask

   task automatic start_header(input int tkl);
      logic [7:0] hi;
      hi = 8'($urandom);
      frame_q.push_back({hi[7:4], tkl[3:0]});
      put_bytes(3 + tkl);
   endtask

   task automatic queue_frame();
      int n;
      n = frame_q.size();
      for (int i = 0; i < n; i++) byte_queue.push_back({frame_q[i], i == n - 1});
      queued_bytes += n;
      queued_frames++;
      frame_q.delete();
   endtask

   task automatic directed_frames();
      // datagrams that stop inside the fixed header
      frame_q.push_back(8'hA5);
      queue_frame();
      frame_q.push_back(8'h12);
      frame_q.push_back(8'h45);
      queue_frame();
      start_header(0);
      queue_frame();
      // token length fifteen, cut inside the token
      frame_q.push_back(8'h3F);
      put_bytes(8);
      queue_frame();
      // URI-Path then payload
      start_header(0);
      put_option(int'(URI_PATH_OPT), 3);
      frame_q.push_back(PAYLOAD_MARKER);
      put_bytes(2);
      queue_frame();
      // repeated URI-Path, odd Block2, options ended by a zero byte
      start_header(2);
      put_option(int'(URI_PATH_OPT), 2);
      put_option(0, 5);
      put_option(int'(BLOCK2_OPT - URI_PATH_OPT), 1);
      frame_q.push_back(OPTIONS_END);
      put_bytes(3);
      queue_frame();
      // Block1 reached through a delta extension, marker as the last byte
      start_header(0);
      frame_q.push_back({EXT_NIBBLE, 4'd3});
      frame_q.push_back(8'(BLOCK1_OPT - 12'(EXT_NIBBLE)));
      put_bytes(3);
      frame_q.push_back(PAYLOAD_MARKER);
      queue_frame();
      // even Block2 length, then odd Block1 cut before its value
      start_header(1);
      put_option(int'(BLOCK2_OPT), 2);
      frame_q.push_back({4'(BLOCK1_OPT - BLOCK2_OPT), 4'd1});
      queue_frame();
      // literal nibbles fourteen and fifteen
      start_header(0);
      frame_q.push_back(8'hEE);
      put_bytes(14);
      frame_q.push_back(8'hFE);
      put_bytes(14);
      frame_q.push_back(OPTIONS_END);
      queue_frame();
      // longest URI-Path length, cut inside the value
      start_header(0);
      frame_q.push_back({URI_PATH_OPT[3:0], EXT_NIBBLE});
      frame_q.push_back(8'hFF);
      put_bytes(20);
      queue_frame();
      // option number saturates
      start_header(0);
      repeat (16) begin
         frame_q.push_back({EXT_NIBBLE, 4'd0});
         frame_q.push_back(8'hFF);
      end
      put_option(1, 1);
      frame_q.push_back(PAYLOAD_MARKER);
      queue_frame();
      // oversized datagram with the marker at the last counted offset
      start_header(0);
      frame_q.push_back({4'd1, EXT_NIBBLE});
      frame_q.push_back(8'd236);
      put_bytes(249);
      frame_q.push_back(PAYLOAD_MARKER);
      put_bytes(44);
      queue_frame();
      // marker right after the header, or zero byte right after the token
      start_header(0);
      frame_q.push_back(PAYLOAD_MARKER);
      queue_frame();
      start_header(3);
      frame_q.push_back(OPTIONS_END);
      put_bytes(2);
      queue_frame();
   endtask

   task automatic random_frame();
      int shape;
      int nopts;
      int number;
      int pick;
      int target;
      int delta;
      int len;
      int ending;
      int cut;
      number = 0;
      shape = $urandom_range(0, 19);
      if (shape < 3) begin
         put_bytes($urandom_range(1, 30));
      end else begin
         start_header(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                  : $urandom_range(0, 8));
         if (shape == 3) begin
            repeat ($urandom_range(15, 17)) put_option($urandom_range(200, MAX_EXT), 0);
            number = int'(OPT_MAX);
         end
         nopts = $urandom_range(0, 6);
         for (int k = 0; k < nopts; k++) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: target = int'(URI_PATH_OPT);
               1: target = int'(BLOCK2_OPT);
               2: target = int'(BLOCK1_OPT);
               3: target = number;
               4: target = number + $urandom_range(1, 12);
               default: target = number + $urandom_range(1, MAX_EXT);
            endcase
            if (target < number) target = number + $urandom_range(1, 12);
            delta = target - number;
            number = (target > int'(OPT_MAX)) ? int'(OPT_MAX) : target;
            pick = $urandom_range(0, 9);
            if (shape == 4 && k == 0) len = $urandom_range(200, MAX_EXT);
            else if (pick < 6) len = $urandom_range(0, 12);
            else if (pick < 9) len = $urandom_range(13, 40);
            else len = $urandom_range(41, 120);
            put_option(delta, len);
         end
         ending = $urandom_range(0, 9);
         if (ending < 6) begin
            frame_q.push_back(PAYLOAD_MARKER);
            put_bytes($urandom_range(0, 8));
         end else if (ending == 6) begin
            frame_q.push_back(OPTIONS_END);
            put_bytes($urandom_range(0, 4));
         end else if (ending == 7) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) frame_q.delete(frame_q.size() - 1);
         end
      end
      queue_frame();
   endtask

   // ---- request driver: bursts with random gaps ----

   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.byte_value <= '0;
         req_ch.last_byte <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_byte(byte_queue.pop_front());
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || byte_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               req_ch.byte_value <= byte_queue[0].value;
               req_ch.last_byte <= byte_queue[0].last;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // ---- response monitor: stall pattern rotates among four modes ----

   int monitor_cycle = 0;

   task automatic check_report();
      result_type want;
      if (expected_reports.size() == 0) begin
         report("report with no datagram outstanding");
      end else begin
         want = expected_reports.pop_front();
         if (rsp_ch.token_length !== want.token_length)
            report($sformatf("token_length got %0d expected %0d",
                             rsp_ch.token_length, want.token_length));
         if (rsp_ch.method_code !== want.method_code)
            report($sformatf("method_code got %0d expected %0d",
                             rsp_ch.method_code, want.method_code));
         if (rsp_ch.uri_offset !== want.uri_offset)
            report($sformatf("uri_offset got %0d expected %0d",
                             rsp_ch.uri_offset, want.uri_offset));
         if (rsp_ch.uri_length !== want.uri_length)
            report($sformatf("uri_length got %0d expected %0d",
                             rsp_ch.uri_length, want.uri_length));
         if (rsp_ch.block_value !== want.block_value)
            report($sformatf("block_value got %0d expected %0d",
                             rsp_ch.block_value, want.block_value));
         if (rsp_ch.payload_offset !== want.payload_offset)
            report($sformatf("payload_offset got %0d expected %0d",
                             rsp_ch.payload_offset, want.payload_offset));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) check_report();
         monitor_cycle++;
         case ((monitor_cycle / 300) % 4)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= (monitor_cycle % 24 == 0);
            default: rsp_ch.ready <= $urandom_range(0, 1);
         endcase
      end
   end

   // ---- stimulus and end of run ----

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.byte_value = '0;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready = 1'b0;
      clear_scanner();
      directed_frames();
      while (queued_bytes < BYTE_TARGET || queued_frames < MIN_FRAMES) random_frame();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_ch.valid || expected_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== coap_header_option_parser.f =====
+incdir+src
src/chop_pkg.sv
src/chop_if.sv
src/chop_scanner.sv
src/coap_header_option_parser.sv
verif/testbench.sv
